// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and codes of the text console character writer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tcw_pkg;

    // Store and position widths
    localparam int MAX_CELLS_DEF = 8192;
    localparam int CELL_W        = 16;
    localparam int CUR_W         = 13;
    localparam int POS_W         = 14;
    localparam int COL_W         = 8;
    localparam int ROW_W         = 7;
    localparam int DIV_CNT_W     = $clog2(POS_W);

    // Register reset values
    localparam logic [COL_W-1:0] DEF_COLUMNS = 8'd80;
    localparam logic [ROW_W-1:0] DEF_ROWS    = 7'd25;
    localparam logic [7:0]       DEF_ATTR    = 8'h07;

    // Character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_NEWLINE   = 8'h0a;
    localparam logic [7:0] CH_BLANK     = 8'h20;

    localparam logic [CELL_W-1:0] RESET_CELL = {DEF_ATTR, CH_BLANK};

    // Opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;
    localparam logic [1:0] REG_ATTR    = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [7:0]       char_code;
        logic             use_offset;
        logic [CUR_W-1:0] cell_offset;
        logic             fg_valid;
        logic [3:0]       fg_color;
        logic             bg_valid;
        logic [3:0]       bg_color;
        logic             move_cursor;
    } in_item_t;

    typedef struct packed {
        logic [CUR_W-1:0] cursor_pos;
        logic [7:0]       read_char;
        logic [7:0]       read_attr;
        logic             scrolled;
    } out_item_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_PUT,
        K_NEWLINE,
        K_BKSP,
        K_CLEAR,
        K_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       ch;
        logic [7:0]       attr;
        logic             use_offset;
        logic [CUR_W-1:0] offset;
        logic             move;
    } cmd_t;

    // Effective screen geometry, zero columns or rows already read as one
    typedef struct packed {
        logic [COL_W-1:0] cols;
        logic [ROW_W-1:0] rows;
        logic [7:0]       attr;
        logic [POS_W-1:0] total;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_BK_RD,
        ST_BK_WR,
        ST_RD_DONE,
        ST_MOVE,
        ST_SHIFT,
        ST_FILL,
        ST_FINISH
    } eng_state_t;

endpackage

`default_nettype wire

// ===== rtl/text_console_char_writer.sv =====
// Text console character writer: input s_ channel of console operations,
// output m_ channel with one result item per input item, and a plain register
// write port for columns, rows and the default attribute.
// Each accepted item gives exactly one result: the cursor after the item,
// the cell read (read opcode only) and whether the screen scrolled or cleared.
// A character put goes through the engine's idle, execute, cursor and result
// steps; a read stores the cell read, a backspace blanks the character of the
// cell before the position, and a newline waits on the iterative remainder unit.
// A scroll moves every cell below the top row up one row and then blanks the
// bottom row; a clear blanks every cell, with columns * rows saturated at MAX_CELLS.
// The engine runs one item at a time and takes no new item before the last
// one has reached its result step, where it waits for room in the result register.
// A two-entry queue sits between the input side and the engine, and the result
// register lets the engine work on the next item while a result waits.
// Reset (aresetn low, synchronous) sets the cursor home and registers to
// 80 x 25 with attribute 0x07, then clears all MAX_CELLS cells of the store one
// cell per cycle; s_ready stays low during that pass.
// When m_ready is low the result holds; the queue fills and s_ready drops.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_engine.
`default_nettype none

module text_console_char_writer #(
    parameter int MAX_CELLS = tcw_pkg::MAX_CELLS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output tcw_pkg::out_item_t     m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_wdata
);

    localparam logic [16:0] MAX_W = 17'(MAX_CELLS);

    logic [tcw_pkg::COL_W-1:0] columns_reg;
    logic [tcw_pkg::ROW_W-1:0] rows_reg;
    logic [7:0]                attr_reg;
    logic [tcw_pkg::POS_W-1:0] total_reg, total_next;
    logic [tcw_pkg::COL_W-1:0] cols_eff;
    logic [tcw_pkg::ROW_W-1:0] rows_eff;
    logic [14:0]               product;
    tcw_pkg::cfg_t             cfg;

    logic          init_done;
    logic          fifo_full;
    logic          push;
    tcw_pkg::cmd_t push_cmd;
    logic          cmd_pop;
    logic          cmd_valid;
    tcw_pkg::cmd_t cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= tcw_pkg::DEF_COLUMNS;
            rows_reg    <= tcw_pkg::DEF_ROWS;
            attr_reg    <= tcw_pkg::DEF_ATTR;
        end else if (cfg_we) begin
            case (cfg_index)
                tcw_pkg::REG_COLUMNS: columns_reg <= cfg_wdata;
                tcw_pkg::REG_ROWS:    rows_reg    <= cfg_wdata[tcw_pkg::ROW_W-1:0];
                tcw_pkg::REG_ATTR:    attr_reg    <= cfg_wdata;
                default: begin
                end
            endcase
        end
        total_reg <= total_next;
    end

    // screen size, saturated at the store depth; the total is registered from the column and row registers
    assign cols_eff = (columns_reg == '0) ? 8'd1 : columns_reg;
    assign rows_eff = (rows_reg == '0) ? 7'd1 : rows_reg;
    assign product  = 15'(cols_eff) * 15'(rows_eff);

    always_comb begin
        if (17'(product) > MAX_W) begin
            total_next = MAX_W[tcw_pkg::POS_W-1:0];
        end else begin
            total_next = product[tcw_pkg::POS_W-1:0];
        end
    end

    assign cfg.cols  = cols_eff;
    assign cfg.rows  = rows_eff;
    assign cfg.attr  = attr_reg;
    assign cfg.total = total_reg;

    tcw_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .default_attr (attr_reg),
        .init_done    (init_done),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tcw_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_cmd   (cmd),
        .not_empty (cmd_valid)
    );

    tcw_engine #(
        .MAX_CELLS (MAX_CELLS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .init_done (init_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on tcw_pkg for default sizes.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = tcw_pkg::CELL_W,
    parameter int DEPTH = tcw_pkg::MAX_CELLS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_div.sv =====
// Iterative remainder unit: one quotient bit per cycle, used for newline.
// Depends on tcw_pkg for position and column widths.
`default_nettype none

module tcw_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [tcw_pkg::POS_W-1:0] dividend,
    input  wire logic [tcw_pkg::COL_W-1:0] divisor,
    output logic                           done,
    output logic      [tcw_pkg::COL_W-1:0] remainder
);

    localparam int PW = tcw_pkg::POS_W;
    localparam int CW = tcw_pkg::COL_W;
    localparam int NW = tcw_pkg::DIV_CNT_W;
    localparam logic [NW-1:0] LAST_STEP = NW'(PW - 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] dvd_reg, dvd_next;
    logic [CW-1:0] dsr_reg, dsr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[PW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // restoring step: subtract when the partial remainder allows it
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = CW'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[CW-1:0];
            end
            dvd_next = {dvd_reg[PW-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/tcw_fifo.sv =====
// Two-entry command queue between the front and the engine.
// Depends on tcw_pkg for the command type.
`default_nettype none

module tcw_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire tcw_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output tcw_pkg::cmd_t      pop_cmd,
    output logic               not_empty
);

    tcw_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== rtl/tcw_front.sv =====
// Input side: accepts items and turns them into engine commands.
// Depends on tcw_pkg for item, command and code definitions.
`default_nettype none

module tcw_front (
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire tcw_pkg::in_item_t s_data,
    input  wire logic [7:0]        default_attr,
    input  wire logic              init_done,
    input  wire logic              fifo_full,
    output logic                   push,
    output tcw_pkg::cmd_t          push_cmd
);

    logic [7:0] put_attr;

    // hold off while the store is still being cleared after reset or while the queue is full
    assign s_ready = init_done && !fifo_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        put_attr = default_attr;
        if (s_data.fg_valid) begin
            put_attr[3:0] = s_data.fg_color;
        end
        if (s_data.bg_valid) begin
            put_attr[7:4] = s_data.bg_color;
        end

        push_cmd.ch         = s_data.char_code;
        push_cmd.attr       = put_attr;
        push_cmd.use_offset = s_data.use_offset;
        push_cmd.offset     = s_data.cell_offset;
        push_cmd.move       = s_data.move_cursor;
        push_cmd.kind       = tcw_pkg::K_NOP;

        unique case (s_data.opcode)
            tcw_pkg::OP_PUT: begin
                if (s_data.char_code == tcw_pkg::CH_NUL) begin
                    push_cmd.kind = tcw_pkg::K_NOP;
                end else if (s_data.char_code == tcw_pkg::CH_NEWLINE) begin
                    push_cmd.kind = tcw_pkg::K_NEWLINE;
                end else if (s_data.char_code == tcw_pkg::CH_BACKSPACE) begin
                    push_cmd.kind = tcw_pkg::K_BKSP;
                end else begin
                    push_cmd.kind = tcw_pkg::K_PUT;
                end
            end
            tcw_pkg::OP_CLEAR: begin
                push_cmd.kind = tcw_pkg::K_CLEAR;
                push_cmd.attr = {s_data.bg_color, 4'h0};
            end
            tcw_pkg::OP_READ: begin
                push_cmd.kind = tcw_pkg::K_READ;
            end
            default: begin
                push_cmd.kind = tcw_pkg::K_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_engine.sv =====
// Back end: cell store, cursor, sequencer for puts, scrolls, clears and reads.
// Depends on tcw_pkg, tcw_ram and tcw_div.
`default_nettype none

module tcw_engine #(
    parameter int MAX_CELLS = tcw_pkg::MAX_CELLS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire tcw_pkg::cfg_t cfg,
    input  wire logic          cmd_valid,
    input  wire tcw_pkg::cmd_t cmd,
    output logic               cmd_pop,
    output logic               init_done,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tcw_pkg::out_item_t m_data
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int PW = tcw_pkg::POS_W;
    localparam int UW = tcw_pkg::CUR_W;
    localparam logic [16:0]   MAX_W     = 17'(MAX_CELLS);
    localparam logic [AW-1:0] INIT_LAST = AW'(MAX_CELLS - 1);

    tcw_pkg::eng_state_t state_reg, state_next;
    tcw_pkg::cmd_t       cmd_reg, cmd_next;
    tcw_pkg::out_item_t  out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [AW-1:0]       init_cnt_reg, init_cnt_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [UW-1:0]       cursor_reg, cursor_next;
    logic [15:0]         fill_val_reg, fill_val_next;
    logic [7:0]          rchar_reg, rchar_next;
    logic [7:0]          rattr_reg, rattr_next;
    logic                scrolled_reg, scrolled_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;
    logic          div_start, div_done;
    logic [7:0]    div_rem;

    logic [PW-1:0] cols_w;
    logic [PW-1:0] shift_n;
    logic [PW-1:0] move_n;
    logic          in_screen;

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tcw_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (pos_reg),
        .divisor   (cfg.cols),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign cols_w    = PW'(cfg.cols);
    assign shift_n   = (cols_w < cfg.total) ? cols_w : cfg.total;
    assign move_n    = cfg.total - shift_n;
    assign in_screen = (pos_reg < cfg.total);
    assign init_done = (state_reg != tcw_pkg::ST_INIT);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcw_pkg::ST_INIT;
            out_valid_reg <= 1'b0;
            init_cnt_reg  <= '0;
            cursor_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            init_cnt_reg  <= init_cnt_next;
            cursor_reg    <= cursor_next;
        end
        cmd_reg      <= cmd_next;
        out_reg      <= out_next;
        pos_reg      <= pos_next;
        ptr_reg      <= ptr_next;
        fill_val_reg <= fill_val_next;
        rchar_reg    <= rchar_next;
        rattr_reg    <= rattr_next;
        scrolled_reg <= scrolled_next;
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        init_cnt_next  = init_cnt_reg;
        pos_next       = pos_reg;
        ptr_next       = ptr_reg;
        cursor_next    = cursor_reg;
        fill_val_next  = fill_val_reg;
        rchar_next     = rchar_reg;
        rattr_next     = rattr_reg;
        scrolled_next  = scrolled_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        cmd_pop        = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            tcw_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = init_cnt_reg;
                ram_wdata = tcw_pkg::RESET_CELL;
                if (init_cnt_reg == INIT_LAST) begin
                    state_next = tcw_pkg::ST_IDLE;
                end else begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop       = 1'b1;
                    cmd_next      = cmd;
                    pos_next      = cmd.use_offset ? PW'(cmd.offset) : PW'(cursor_reg);
                    scrolled_next = 1'b0;
                    rchar_next    = '0;
                    rattr_next    = '0;
                    state_next    = tcw_pkg::ST_EXEC;
                end
            end
            tcw_pkg::ST_EXEC: begin
                unique case (cmd_reg.kind)
                    tcw_pkg::K_PUT: begin
                        if (in_screen) begin
                            ram_we    = 1'b1;
                            ram_waddr = AW'(pos_reg);
                            ram_wdata = {cmd_reg.attr, cmd_reg.ch};
                        end
                        pos_next   = pos_reg + 1'b1;
                        state_next = tcw_pkg::ST_MOVE;
                    end
                    tcw_pkg::K_NEWLINE: begin
                        div_start  = 1'b1;
                        state_next = tcw_pkg::ST_DIV;
                    end
                    tcw_pkg::K_BKSP: begin
                        if (pos_reg != '0) begin
                            pos_next = pos_reg - 1'b1;
                        end
                        state_next = tcw_pkg::ST_BK_RD;
                    end
                    tcw_pkg::K_CLEAR: begin
                        fill_val_next = {cmd_reg.attr, tcw_pkg::CH_BLANK};
                        ptr_next      = '0;
                        cursor_next   = '0;
                        scrolled_next = 1'b1;
                        state_next    = tcw_pkg::ST_FILL;
                    end
                    tcw_pkg::K_READ: begin
                        if (17'(pos_reg) < MAX_W) begin
                            ram_re     = 1'b1;
                            ram_raddr  = AW'(pos_reg);
                            state_next = tcw_pkg::ST_RD_DONE;
                        end else begin
                            state_next = tcw_pkg::ST_FINISH;
                        end
                    end
                    default: begin
                        state_next = tcw_pkg::ST_FINISH;
                    end
                endcase
            end
            tcw_pkg::ST_DIV: begin
                if (div_done) begin
                    pos_next   = pos_reg + cols_w - PW'(div_rem);
                    state_next = tcw_pkg::ST_MOVE;
                end
            end
            tcw_pkg::ST_BK_RD: begin
                if (in_screen) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(pos_reg);
                    state_next = tcw_pkg::ST_BK_WR;
                end else begin
                    state_next = tcw_pkg::ST_MOVE;
                end
            end
            tcw_pkg::ST_BK_WR: begin
                // keep the attribute, blank the character
                ram_we     = 1'b1;
                ram_waddr  = AW'(pos_reg);
                ram_wdata  = {ram_rdata[15:8], tcw_pkg::CH_BLANK};
                state_next = tcw_pkg::ST_MOVE;
            end
            tcw_pkg::ST_RD_DONE: begin
                rchar_next = ram_rdata[7:0];
                rattr_next = ram_rdata[15:8];
                state_next = tcw_pkg::ST_FINISH;
            end
            tcw_pkg::ST_MOVE: begin
                state_next = tcw_pkg::ST_FINISH;
                if (cmd_reg.move) begin
                    if (in_screen) begin
                        cursor_next = UW'(pos_reg);
                    end else begin
                        scrolled_next = 1'b1;
                        ptr_next      = '0;
                        if (cfg.rows == 7'd1) begin
                            // single row: clear with the default background
                            fill_val_next = {cfg.attr[7:4], 4'h0, tcw_pkg::CH_BLANK};
                            cursor_next   = '0;
                            state_next    = tcw_pkg::ST_FILL;
                        end else begin
                            fill_val_next = {cfg.attr, tcw_pkg::CH_BLANK};
                            cursor_next   = (pos_reg < cols_w) ? '0 : UW'(pos_reg - cols_w);
                            state_next    = tcw_pkg::ST_SHIFT;
                        end
                    end
                end
            end
            tcw_pkg::ST_SHIFT: begin
                // read one row ahead, write back what was read last cycle
                if (ptr_reg < move_n) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ptr_reg + shift_n);
                end
                if (ptr_reg != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(ptr_reg - 1'b1);
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg == move_n) begin
                    state_next = tcw_pkg::ST_FILL;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            tcw_pkg::ST_FILL: begin
                if (ptr_reg < cfg.total) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(ptr_reg);
                    ram_wdata = fill_val_reg;
                    ptr_next  = ptr_reg + 1'b1;
                end else begin
                    state_next = tcw_pkg::ST_FINISH;
                end
            end
            tcw_pkg::ST_FINISH: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next      = 1'b1;
                    out_next.cursor_pos = cursor_reg;
                    out_next.read_char  = rchar_reg;
                    out_next.read_attr  = rattr_reg;
                    out_next.scrolled   = scrolled_reg;
                    state_next          = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tcw_pkg::ST_IDLE |-> !ram_we)
        else $error("store written while idle");

    a_write_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && state_reg != tcw_pkg::ST_INIT |-> 17'(ram_waddr) < 17'(cfg.total))
        else $error("store write beyond the screen");

    a_shift_multirow: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tcw_pkg::ST_SHIFT |-> cfg.rows > 7'd1)
        else $error("row move on a single-row screen");

    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !cmd_pop)
        else $error("command taken before the store is cleared");
`endif

endmodule

`default_nettype wire
